>>> sv/lspt_pkg.sv
// Shared constants, status codes and controller/datapath handshake types.
package lspt_pkg;

   localparam int DEF_WINDOW       = 3;
   localparam int DEF_SENSOR_COUNT = 8;
   localparam int DEF_COUNTER_BITS = 16;

   localparam int POS_SCALE = 1000;
   localparam int FRAC_BITS = 8;

   localparam int THR_W     = 4;
   localparam int POS_W     = 13;
   localparam int STATUS_W  = 2;
   localparam int TOTAL_W   = 16;
   localparam int ACTIVE_W  = 4;

   localparam logic [THR_W-1:0] THR_RESET = THR_W'(5);

   localparam logic [STATUS_W-1:0] STATUS_NORMAL    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_LOST      = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_INTERSECT = 2'd2;

   typedef struct packed {
      logic load_input;
      logic prep;
      logic div_start;
      logic div_sel_avg;
      logic ring_write;
      logic sum_step;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic sum_last;
   } stat_type;

endpackage

>>> sv/lspt_req_if.sv
// Request channel: one sensor word per handshake.
interface lspt_req_if import lspt_pkg::*; #(
   parameter int SENSOR_COUNT = DEF_SENSOR_COUNT
);
   logic                    valid;
   logic                    ready;
   logic [SENSOR_COUNT-1:0] sensor_bits;
   logic                    decide_enable;

   modport source (output valid, output sensor_bits, output decide_enable, input ready);
   modport sink   (input valid, input sensor_bits, input decide_enable, output ready);
endinterface

>>> sv/lspt_rsp_if.sv
// Response channel: one tracking result word per handshake.
interface lspt_rsp_if import lspt_pkg::*;;
   logic                 valid;
   logic                 ready;
   logic [POS_W-1:0]     position;
   logic [STATUS_W-1:0]  line_status;
   logic [TOTAL_W-1:0]   lost_total;
   logic [TOTAL_W-1:0]   intersection_total;
   logic [ACTIVE_W-1:0]  active_sensors;

   modport source (output valid, output position, output line_status, output lost_total,
                   output intersection_total, output active_sensors, input ready);
   modport sink   (input valid, input position, input line_status, input lost_total,
                   input intersection_total, input active_sensors, output ready);
endinterface

>>> sv/lspt_divider.sv
// Restoring divider, one quotient bit per cycle.
module lspt_divider import lspt_pkg::*; #(
   parameter int NW = 25,
   parameter int DW = 4
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] dividend,
   input  logic [DW-1:0] divisor,
   output logic          done,
   output logic [NW-1:0] quotient
);
   localparam int STEP_W = (NW > 1) ? $clog2(NW) : 1;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [NW-1:0]     num_ff, num_in;
   logic [DW-1:0]     rem_ff, rem_in;
   logic [DW-1:0]     den_ff, den_in;
   logic [DW:0]       trial;
   logic [DW:0]       diff;
   logic              fits;

   always_comb begin
      trial   = {rem_ff, num_ff[NW-1]};
      diff    = trial - {1'b0, den_ff};
      fits    = trial >= {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         num_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
      end else if (busy_ff) begin
         // shift in one dividend bit, subtract when the divisor fits
         rem_in  = fits ? diff[DW-1:0] : trial[DW-1:0];
         num_in  = {num_ff[NW-2:0], fits};
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(NW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      num_ff  <= num_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
   end

   assign done     = done_ff;
   assign quotient = num_ff;
endmodule

>>> sv/lspt_datapath.sv
// Centroid, reading ring, averaging and line classification datapath.
module lspt_datapath import lspt_pkg::*; #(
   parameter int WINDOW       = DEF_WINDOW,
   parameter int SENSOR_COUNT = DEF_SENSOR_COUNT,
   parameter int COUNTER_BITS = DEF_COUNTER_BITS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  cmd_type                 cmd,
   output stat_type                stat,
   input  logic [SENSOR_COUNT-1:0] sensor_bits,
   input  logic                    decide_enable,
   input  logic                    csr_wr_en,
   input  logic [THR_W-1:0]        csr_wr_data,
   output logic [POS_W-1:0]        position,
   output logic [STATUS_W-1:0]     line_status,
   output logic [TOTAL_W-1:0]      lost_total,
   output logic [TOTAL_W-1:0]      intersection_total,
   output logic [ACTIVE_W-1:0]     active_sensors
);
   localparam int CNT_W   = $clog2(SENSOR_COUNT + 1);
   localparam int IDX_MAX = SENSOR_COUNT * (SENSOR_COUNT - 1) / 2;
   localparam int IDX_W   = $clog2(IDX_MAX + 1);
   localparam int NUM_W   = $clog2(IDX_MAX * POS_SCALE * (2 ** FRAC_BITS) + 1);
   localparam int RAW_MAX = (SENSOR_COUNT - 1) * POS_SCALE * (2 ** FRAC_BITS);
   localparam int RAW_W   = $clog2(RAW_MAX + 1);
   localparam int ACC_W   = $clog2(WINDOW * RAW_MAX + 1);
   localparam int AVG_NW  = ACC_W - FRAC_BITS;
   localparam int FILL_W  = $clog2(WINDOW + 1);
   localparam int SLOT_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int DIV_NW  = (NUM_W > AVG_NW) ? NUM_W : AVG_NW;
   localparam int DIV_DW  = (CNT_W > FILL_W) ? CNT_W : FILL_W;
   localparam int CMP_W   = (CNT_W > THR_W) ? CNT_W : THR_W;

   // input word and per-reading values
   logic [SENSOR_COUNT-1:0] bits_ff;
   logic                    en_ff;
   logic [CNT_W-1:0]        count_ff;
   logic [NUM_W-1:0]        num_ff;
   logic [CNT_W-1:0]        count_c;
   logic [IDX_W-1:0]        idx_c;

   // ring and running sum
   logic [RAW_W-1:0]  ring_ff [WINDOW];
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [SLOT_W-1:0] sum_idx_ff;
   logic [ACC_W-1:0]  acc_ff;
   logic [RAW_W-1:0]  raw_c;

   // classification state
   logic [THR_W-1:0]        thr_ff;
   logic [STATUS_W-1:0]     status_ff, status_in;
   logic [COUNTER_BITS-1:0] lost_ff, lost_in;
   logic [COUNTER_BITS-1:0] inter_ff, inter_in;
   logic                    inside_ff, inside_in;
   logic [POS_W-1:0]        pos_c;

   // output word
   logic [POS_W-1:0]    pos_ff;
   logic [ACTIVE_W-1:0] active_ff;

   // shared divider
   logic              div_done;
   logic [DIV_NW-1:0] div_quot;
   logic [DIV_NW-1:0] div_num;
   logic [DIV_DW-1:0] div_den;

   always_comb begin
      count_c = '0;
      idx_c   = '0;
      for (int i = 0; i < SENSOR_COUNT; i++) begin
         if (!bits_ff[SENSOR_COUNT-1-i]) begin
            count_c = count_c + CNT_W'(1);
            idx_c   = idx_c + IDX_W'(i);
         end
      end
   end

   assign div_num = cmd.div_sel_avg ? DIV_NW'(acc_ff >> FRAC_BITS) : DIV_NW'(num_ff);
   assign div_den = cmd.div_sel_avg ? DIV_DW'(fill_ff) : DIV_DW'(count_ff);

   lspt_divider #(
      .NW (DIV_NW),
      .DW (DIV_DW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_num),
      .divisor  (div_den),
      .done     (div_done),
      .quotient (div_quot)
   );

   // no active sensor means a raw position of zero
   assign raw_c = (count_ff == '0) ? '0 : div_quot[RAW_W-1:0];

   assign stat.div_done = div_done;
   assign stat.sum_last = (FILL_W'(sum_idx_ff) + FILL_W'(1)) == fill_ff;

   always_comb begin
      slot_in   = slot_ff;
      fill_in   = fill_ff;
      status_in = status_ff;
      lost_in   = lost_ff;
      inter_in  = inter_ff;
      inside_in = inside_ff;
      pos_c     = div_quot[POS_W-1:0];
      if (cmd.ring_write) begin
         slot_in = (slot_ff == SLOT_W'(WINDOW - 1)) ? '0 : slot_ff + SLOT_W'(1);
         if (fill_ff != FILL_W'(WINDOW)) begin
            fill_in = fill_ff + FILL_W'(1);
         end
      end
      if (cmd.finish && en_ff) begin
         if (count_ff == '0) begin
            status_in = STATUS_LOST;
            lost_in   = (lost_ff == '1) ? lost_ff : lost_ff + COUNTER_BITS'(1);
            fill_in   = '0;
            slot_in   = '0;
            pos_c     = '0;
         end else if (CMP_W'(count_ff) >= CMP_W'(thr_ff)) begin
            status_in = STATUS_INTERSECT;
            if (!inside_ff) begin
               inter_in  = (inter_ff == '1) ? inter_ff : inter_ff + COUNTER_BITS'(1);
               inside_in = 1'b1;
            end
         end else begin
            status_in = STATUS_NORMAL;
            inside_in = 1'b0;
            lost_in   = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff    <= THR_RESET;
         slot_ff   <= '0;
         fill_ff   <= '0;
         status_ff <= STATUS_NORMAL;
         lost_ff   <= '0;
         inter_ff  <= '0;
         inside_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            thr_ff <= csr_wr_data;
         end
         slot_ff   <= slot_in;
         fill_ff   <= fill_in;
         status_ff <= status_in;
         lost_ff   <= lost_in;
         inter_ff  <= inter_in;
         inside_ff <= inside_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_input) begin
         bits_ff <= sensor_bits;
         en_ff   <= decide_enable;
      end
      if (cmd.prep) begin
         count_ff <= count_c;
         num_ff   <= (NUM_W'(idx_c) * NUM_W'(POS_SCALE)) << FRAC_BITS;
      end
      if (cmd.ring_write) begin
         ring_ff[slot_ff] <= raw_c;
         sum_idx_ff       <= '0;
         acc_ff           <= '0;
      end
      if (cmd.sum_step) begin
         acc_ff     <= acc_ff + ACC_W'(ring_ff[sum_idx_ff]);
         sum_idx_ff <= sum_idx_ff + SLOT_W'(1);
      end
      if (cmd.finish) begin
         pos_ff    <= pos_c;
         active_ff <= ACTIVE_W'(count_ff);
      end
   end

   assign position           = pos_ff;
   assign line_status        = status_ff;
   assign lost_total         = TOTAL_W'(lost_ff);
   assign intersection_total = TOTAL_W'(inter_ff);
   assign active_sensors     = active_ff;
endmodule

>>> sv/lspt_ctrl.sv
// Sequencing state machine and response handshake.
module lspt_ctrl import lspt_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   input  stat_type stat,
   output cmd_type  cmd
);
   typedef enum logic [3:0] {
      S_IDLE,
      S_PREP,
      S_RAW_GO,
      S_RAW_WAIT,
      S_RING_WR,
      S_SUM,
      S_AVG_GO,
      S_AVG_WAIT,
      S_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_free;

   assign rsp_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         S_IDLE: begin
            cmd.load_input = req_valid;
            if (req_valid) begin
               state_in = S_PREP;
            end
         end
         S_PREP: begin
            cmd.prep = 1'b1;
            state_in = S_RAW_GO;
         end
         S_RAW_GO: begin
            cmd.div_start = 1'b1;
            state_in      = S_RAW_WAIT;
         end
         S_RAW_WAIT: begin
            if (stat.div_done) begin
               state_in = S_RING_WR;
            end
         end
         S_RING_WR: begin
            cmd.ring_write = 1'b1;
            state_in       = S_SUM;
         end
         S_SUM: begin
            cmd.sum_step = 1'b1;
            if (stat.sum_last) begin
               state_in = S_AVG_GO;
            end
         end
         S_AVG_GO: begin
            cmd.div_start   = 1'b1;
            cmd.div_sel_avg = 1'b1;
            state_in        = S_AVG_WAIT;
         end
         S_AVG_WAIT: begin
            if (stat.div_done) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            // hold until the output register is free
            if (rsp_free) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
endmodule

>>> sv/line_sensor_position_tracker.sv
// Each word makes two passes through the shared one-bit-per-cycle divider and a ring sum
//   over the filled entries; a request is accepted only while the controller is idle.
// A finished word waits in the output register; the next request is taken meanwhile.
// Reset (synchronous, active high): empty ring, counters and status zero, threshold 5.
module line_sensor_position_tracker import lspt_pkg::*; #(
   parameter int WINDOW       = DEF_WINDOW,
   parameter int SENSOR_COUNT = DEF_SENSOR_COUNT,
   parameter int COUNTER_BITS = DEF_COUNTER_BITS
) (
   input  logic             clock,
   input  logic             reset,
   lspt_req_if.sink         req_chan,
   lspt_rsp_if.source       rsp_chan,
   input  logic             csr_wr_en,
   input  logic [THR_W-1:0] csr_wr_data
);
   // The controller walks each word through:
   //   accept -> centroid prep -> divide (index sum * 1000 * 256 / count)
   //   -> ring write -> sum filled entries one per cycle
   //   -> divide (sum / 256 / fill) -> classify and load the output register.
   // The datapath owns every register that carries data; the controller only
   // issues commands and watches divider done and sum-last status.
   cmd_type  cmd;
   stat_type stat;

   lspt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Lost readings (enabled, no active sensor) clear the ring and force position 0;
   // when classification is disabled, status and counters hold.
   lspt_datapath #(
      .WINDOW       (WINDOW),
      .SENSOR_COUNT (SENSOR_COUNT),
      .COUNTER_BITS (COUNTER_BITS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .sensor_bits        (req_chan.sensor_bits),
      .decide_enable      (req_chan.decide_enable),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .position           (rsp_chan.position),
      .line_status        (rsp_chan.line_status),
      .lost_total         (rsp_chan.lost_total),
      .intersection_total (rsp_chan.intersection_total),
      .active_sensors     (rsp_chan.active_sensors)
   );
endmodule

>>> sv/lspt_checker.sv
// Port-level checks on the tracker's response word, bound to the top level.
module lspt_checker import lspt_pkg::*; #(
   parameter int SENSOR_COUNT = DEF_SENSOR_COUNT
) (
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [STATUS_W-1:0] line_status,
   input logic [TOTAL_W-1:0]  lost_total,
   input logic [ACTIVE_W-1:0] active_sensors
);
   // a word once offered stays until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped before handshake");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (line_status == STATUS_NORMAL || line_status == STATUS_LOST ||
                     line_status == STATUS_INTERSECT))
      else $error("undefined line status");

   // a normal reading always clears the loss run
   a_normal_no_loss: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && line_status == STATUS_NORMAL |-> lost_total == '0)
      else $error("loss count nonzero with normal status");

   a_active_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (SENSOR_COUNT > 15 || active_sensors <= ACTIVE_W'(SENSOR_COUNT)))
      else $error("active sensor count out of range");
endmodule

bind line_sensor_position_tracker lspt_checker #(
   .SENSOR_COUNT (SENSOR_COUNT)
) u_lspt_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .line_status    (rsp_chan.line_status),
   .lost_total     (rsp_chan.lost_total),
   .active_sensors (rsp_chan.active_sensors)
);
